// ----- src/fast_inverse_sqrt_assert.svh -----
// Assertion macros shared by the fast inverse square root RTL.
// Included by fast_inverse_sqrt, which checks its own pipeline control.
`ifndef FAST_INVERSE_SQRT_ASSERT_SVH
`define FAST_INVERSE_SQRT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FIS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FIS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/fis_pkg.sv -----
// Package for the fast inverse square root block.
// Holds binary32 constants and pipeline latencies; no dependencies.
`default_nettype none
package fis_pkg;

  localparam logic [31:0] GuessMagic  = 32'h5F3759DF;
  localparam logic [31:0] HalfBits    = 32'h3F000000;
  localparam logic [31:0] OneHalfBits = 32'h3FC00000;
  localparam logic [31:0] DefaultNan  = 32'hFFC00000;
  localparam logic [31:0] QuietBit    = 32'h00400000;
  localparam logic [7:0]  ExpMax      = 8'hFF;

  localparam int unsigned MulLat   = 3;
  localparam int unsigned SubLat   = 3;
  localparam int unsigned RoundLat = 3 * MulLat + SubLat;

endpackage
`default_nettype wire

// ----- src/fis_fmul.sv -----
// Three-stage binary32 multiplier, round to nearest even, full IEEE special cases.
// Uses fis_pkg constants.
`default_nettype none
module fis_fmul (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [31:0] p_o
);

  // Stage 1: unpack, specials, mantissa product.
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
  logic [23:0] ma, mb;
  logic [7:0]  ea, eb;
  logic        spec_d;
  logic [31:0] specv_d;

  always_comb begin
    a_nan  = (a_i[30:23] == fis_pkg::ExpMax) && (a_i[22:0] != '0);
    b_nan  = (b_i[30:23] == fis_pkg::ExpMax) && (b_i[22:0] != '0);
    a_inf  = (a_i[30:23] == fis_pkg::ExpMax) && (a_i[22:0] == '0);
    b_inf  = (b_i[30:23] == fis_pkg::ExpMax) && (b_i[22:0] == '0);
    a_zero = (a_i[30:0] == '0);
    b_zero = (b_i[30:0] == '0);
    sgn    = a_i[31] ^ b_i[31];
    ea     = (a_i[30:23] == '0) ? 8'd1 : a_i[30:23];
    eb     = (b_i[30:23] == '0) ? 8'd1 : b_i[30:23];
    ma     = {a_i[30:23] != '0, a_i[22:0]};
    mb     = {b_i[30:23] != '0, b_i[22:0]};
    spec_d  = 1'b1;
    specv_d = {sgn, fis_pkg::ExpMax, 23'b0};
    if (a_nan) begin
      specv_d = a_i | fis_pkg::QuietBit;
    end else if (b_nan) begin
      specv_d = b_i | fis_pkg::QuietBit;
    end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
      specv_d = fis_pkg::DefaultNan;
    end else if (!(a_inf || b_inf)) begin
      spec_d = 1'b0;
    end
  end

  logic [47:0] prod_q;
  logic [8:0]  esum_q;
  logic        sgn1_q, spec1_q;
  logic [31:0] specv1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= ma * mb;
      esum_q   <= {1'b0, ea} + {1'b0, eb};
      sgn1_q   <= sgn;
      spec1_q  <= spec_d;
      specv1_q <= specv_d;
    end
  end

  // Stage 2: leading one, shift amount and biased exponent.
  logic [5:0]         pos;
  logic signed [10:0] s_norm, s_sub, s_sel, t_full, be_full;
  logic [7:0]         t_d;

  always_comb begin
    pos = '0;
    for (int i = 0; i < 48; i++) begin
      if (prod_q[i]) pos = 6'(i);
    end
    s_norm  = $signed({5'b0, pos}) - 11'sd23;
    s_sub   = 11'sd151 - $signed({2'b0, esum_q});
    s_sel   = (s_norm > s_sub) ? s_norm : s_sub;
    t_full  = s_sel + 11'sd24;
    t_d     = (t_full > 11'sd74) ? 8'd74 : t_full[7:0];
    be_full = s_sel + $signed({2'b0, esum_q}) - 11'sd151;
  end

  logic [47:0] prod2_q;
  logic [7:0]  t_q;
  logic [8:0]  be_q;
  logic        zero_q, sgn2_q, spec2_q;
  logic [31:0] specv2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod2_q  <= prod_q;
      t_q      <= t_d;
      be_q     <= be_full[8:0];
      zero_q   <= (prod_q == '0);
      sgn2_q   <= sgn1_q;
      spec2_q  <= spec1_q;
      specv2_q <= specv1_q;
    end
  end

  // Stage 3: align, round to nearest even, pack.
  logic [72:0] w, wr, mask;
  logic        sticky, g, up, ovf;
  logic [23:0] m;
  logic [32:0] sum;
  logic [31:0] res_d;

  always_comb begin
    w      = {prod2_q, 25'b0};
    wr     = w >> t_q;
    mask   = ~({73{1'b1}} << t_q);
    sticky = |(w & mask);
    m      = wr[24:1];
    g      = wr[0];
    up     = g & (sticky | m[0]);
    sum    = {1'b0, be_q, 23'b0} + {9'b0, m} + {32'b0, up};
    ovf    = (sum >= 33'h07F800000);
    if (spec2_q) begin
      res_d = specv2_q;
    end else if (zero_q) begin
      res_d = {sgn2_q, 31'b0};
    end else if (ovf) begin
      res_d = {sgn2_q, fis_pkg::ExpMax, 23'b0};
    end else begin
      res_d = {sgn2_q, sum[30:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o <= res_d;
    end
  end

endmodule
`default_nettype wire

// ----- src/fis_fsub.sv -----
// Three-stage binary32 subtractor a - b, round to nearest even, IEEE specials.
// Uses fis_pkg constants.
`default_nettype none
module fis_fsub (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [31:0] d_o
);

  // Stage 1: specials, order by magnitude.
  logic        sa, sb, a_nan, b_nan, a_inf, b_inf, swap, spec_d;
  logic [31:0] specv_d, big, sml;
  logic [7:0]  e1, e2;

  always_comb begin
    sa    = a_i[31];
    sb    = ~b_i[31];
    a_nan = (a_i[30:23] == fis_pkg::ExpMax) && (a_i[22:0] != '0);
    b_nan = (b_i[30:23] == fis_pkg::ExpMax) && (b_i[22:0] != '0);
    a_inf = (a_i[30:23] == fis_pkg::ExpMax) && (a_i[22:0] == '0);
    b_inf = (b_i[30:23] == fis_pkg::ExpMax) && (b_i[22:0] == '0);
    spec_d  = 1'b1;
    specv_d = fis_pkg::DefaultNan;
    if (a_nan) begin
      specv_d = a_i | fis_pkg::QuietBit;
    end else if (b_nan) begin
      specv_d = b_i | fis_pkg::QuietBit;
    end else if (a_inf && b_inf && (sa != sb)) begin
      specv_d = fis_pkg::DefaultNan;
    end else if (a_inf) begin
      specv_d = {sa, fis_pkg::ExpMax, 23'b0};
    end else if (b_inf) begin
      specv_d = {sb, fis_pkg::ExpMax, 23'b0};
    end else begin
      spec_d = 1'b0;
    end
    swap = (b_i[30:0] > a_i[30:0]);
    big  = swap ? b_i : a_i;
    sml  = swap ? a_i : b_i;
    e1   = (big[30:23] == '0) ? 8'd1 : big[30:23];
    e2   = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
  end

  logic [23:0] m1_q, m2_q;
  logic [7:0]  e1_q, d_q;
  logic        sbig_q, sub_q, zsgn_q, spec1_q;
  logic [31:0] specv1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q     <= {big[30:23] != '0, big[22:0]};
      m2_q     <= {sml[30:23] != '0, sml[22:0]};
      e1_q     <= e1;
      d_q      <= e1 - e2;
      sbig_q   <= swap ? sb : sa;
      sub_q    <= (sa != sb);
      zsgn_q   <= sa & sb;
      spec1_q  <= spec_d;
      specv1_q <= specv_d;
    end
  end

  // Stage 2: align the smaller operand with sticky, then add or subtract.
  logic [4:0]  d5;
  logic [26:0] bx, bs, bb, aa;
  logic        st;

  always_comb begin
    d5 = (d_q > 8'd31) ? 5'd31 : d_q[4:0];
    bx = {m2_q, 3'b0};
    bs = bx >> d5;
    st = |(bx & ~({27{1'b1}} << d5));
    bb = {bs[26:1], bs[0] | st};
    aa = {m1_q, 3'b0};
  end

  logic [27:0] s_q;
  logic [7:0]  e1b_q;
  logic        sbig2_q, zsgn2_q, spec2_q;
  logic [31:0] specv2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q      <= sub_q ? ({1'b0, aa} - {1'b0, bb}) : ({1'b0, aa} + {1'b0, bb});
      e1b_q    <= e1_q;
      sbig2_q  <= sbig_q;
      zsgn2_q  <= zsgn_q;
      spec2_q  <= spec1_q;
      specv2_q <= specv1_q;
    end
  end

  // Stage 3: normalize, round to nearest even, pack.
  logic [4:0]  pos;
  logic [7:0]  lim_a, lim_b, k;
  logic [26:0] nrm;
  logic [8:0]  e;
  logic [23:0] mant;
  logic        up, ovf;
  logic [32:0] sum;
  logic [31:0] res_d;

  always_comb begin
    pos = '0;
    for (int i = 0; i < 28; i++) begin
      if (s_q[i]) pos = 5'(i);
    end
    lim_a = 8'd26 - {3'b0, pos};
    lim_b = e1b_q - 8'd1;
    k     = (lim_a < lim_b) ? lim_a : lim_b;
    if (s_q[27]) begin
      nrm = {s_q[27:2], s_q[1] | s_q[0]};
      e   = {1'b0, e1b_q} + 9'd1;
    end else begin
      nrm = s_q[26:0] << k;
      e   = {1'b0, e1b_q} - {1'b0, k};
    end
    mant = nrm[26:3];
    up   = nrm[2] & (nrm[1] | nrm[0] | mant[0]);
    sum  = {1'b0, e - 9'd1, 23'b0} + {9'b0, mant} + {32'b0, up};
    ovf  = (sum >= 33'h07F800000);
    if (spec2_q) begin
      res_d = specv2_q;
    end else if (s_q == '0) begin
      res_d = {zsgn2_q, 31'b0};
    end else if (ovf) begin
      res_d = {sbig2_q, fis_pkg::ExpMax, 23'b0};
    end else begin
      res_d = {sbig2_q, sum[30:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_o <= res_d;
    end
  end

endmodule
`default_nettype wire

// ----- src/fis_round.sv -----
// One Newton round y * (1.5 - (xhalf * y) * y) as a twelve-stage pipeline.
// Uses fis_fmul, fis_fsub and fis_pkg; passes y through when IDX is not below the round count.
`default_nettype none
module fis_round #(
  parameter int unsigned NW  = 3,
  parameter int unsigned IDX = 0
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [31:0]   xh_i,
  input  wire logic [31:0]   y_i,
  input  wire logic [NW-1:0] n_i,
  output logic      [31:0]   xh_o,
  output logic      [31:0]   y_o,
  output logic      [NW-1:0] n_o
);

  localparam int unsigned Lat = fis_pkg::RoundLat;

  logic [31:0]   y_q  [Lat];
  logic [31:0]   xh_q [Lat];
  logic [NW-1:0] n_q  [Lat];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q[0]  <= y_i;
      xh_q[0] <= xh_i;
      n_q[0]  <= n_i;
      for (int i = 1; i < Lat; i++) begin
        y_q[i]  <= y_q[i-1];
        xh_q[i] <= xh_q[i-1];
        n_q[i]  <= n_q[i-1];
      end
    end
  end

  logic [31:0] t1, t2, t3, y_new;

  fis_fmul u_mul_xy (.clk_i, .en_i, .a_i(xh_i), .b_i(y_i), .p_o(t1));
  fis_fmul u_mul_ty (.clk_i, .en_i, .a_i(t1), .b_i(y_q[fis_pkg::MulLat-1]), .p_o(t2));
  fis_fsub u_sub (.clk_i, .en_i, .a_i(fis_pkg::OneHalfBits), .b_i(t2), .d_o(t3));
  fis_fmul u_mul_yt (
    .clk_i, .en_i,
    .a_i(y_q[2*fis_pkg::MulLat+fis_pkg::SubLat-1]),
    .b_i(t3),
    .p_o(y_new)
  );

  assign y_o  = (n_q[Lat-1] > NW'(IDX)) ? y_new : y_q[Lat-1];
  assign xh_o = xh_q[Lat-1];
  assign n_o  = n_q[Lat-1];

endmodule
`default_nettype wire

// ----- src/fast_inverse_sqrt.sv -----
// Fast reciprocal square root on binary32 bit patterns: the integer guess
// 0x5f3759df - (x >> 1) followed by newton_rounds Newton steps, each float
// operation rounded to nearest even with IEEE subnormal, NaN and infinity
// handling. One item is accepted every cycle while the output is not held.
// The pipeline is the 0.5 * x multiply, then MAX_ROUNDS round stages
// (three multipliers and one subtractor of three stages each), then one
// output register. Every round stage is always traversed; rounds past
// the configured count pass the value through. Writes above MAX_ROUNDS
// saturate. When the output is held, the whole pipeline holds.
`default_nettype none
`include "fast_inverse_sqrt_assert.svh"
module fast_inverse_sqrt #(
  parameter int unsigned MAX_ROUNDS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream; tdata: [31:0] x_bits.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  // Output stream; tdata: [31:0] inv_sqrt_bits.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,
  // Register newton_rounds.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_data_i
);

  localparam int unsigned NW  = $clog2(MAX_ROUNDS + 1);
  localparam int unsigned Lat = fis_pkg::MulLat + fis_pkg::RoundLat * MAX_ROUNDS;
  localparam logic [3:0]  MaxR = 4'(MAX_ROUNDS);

  logic [2:0] rounds_q;
  logic       pipe_en;
  logic [Lat-1:0] vld_q;

  assign cfg_ready_o   = 1'b1;
  assign pipe_en       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rounds_q <= 3'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rounds_q <= cfg_data_i;
    end
  end

  logic [3:0]    n_sat;
  logic [31:0]   guess;

  assign n_sat = ({1'b0, rounds_q} > MaxR) ? MaxR : {1'b0, rounds_q};
  assign guess = fis_pkg::GuessMagic - {1'b0, s_axis_tdata[31:1]};

  // Guess and round count ride alongside the 0.5 * x multiply.
  logic [31:0]   g_q [fis_pkg::MulLat];
  logic [NW-1:0] n_q [fis_pkg::MulLat];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      g_q[0] <= guess;
      n_q[0] <= n_sat[NW-1:0];
      for (int i = 1; i < fis_pkg::MulLat; i++) begin
        g_q[i] <= g_q[i-1];
        n_q[i] <= n_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  logic [31:0]   xh_w [MAX_ROUNDS+1];
  logic [31:0]   y_w  [MAX_ROUNDS+1];
  logic [NW-1:0] n_w  [MAX_ROUNDS+1];

  fis_fmul u_half (
    .clk_i, .en_i(pipe_en), .a_i(fis_pkg::HalfBits), .b_i(s_axis_tdata), .p_o(xh_w[0])
  );
  assign y_w[0] = g_q[fis_pkg::MulLat-1];
  assign n_w[0] = n_q[fis_pkg::MulLat-1];

  for (genvar r = 0; r < MAX_ROUNDS; r++) begin : g_round
    fis_round #(.NW(NW), .IDX(r)) u_round (
      .clk_i,
      .en_i (pipe_en),
      .xh_i (xh_w[r]),
      .y_i  (y_w[r]),
      .n_i  (n_w[r]),
      .xh_o (xh_w[r+1]),
      .y_o  (y_w[r+1]),
      .n_o  (n_w[r+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (pipe_en) begin
      m_axis_tvalid <= vld_q[Lat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      m_axis_tdata <= y_w[MAX_ROUNDS];
    end
  end

  `FIS_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, !pipe_en, $stable(vld_q), "pipeline moved while stalled")
  `FIS_ASSERT_NXT(a_out_load, clk_i, rst_ni, pipe_en && vld_q[Lat-1], m_axis_tvalid, "result lost at output")
  `FIS_ASSERT_NXT(a_cfg_write, clk_i, rst_ni, cfg_valid_i && cfg_ready_o, rounds_q == $past(cfg_data_i), "register write lost")
  `FIS_ASSERT_IMP(a_no_accept_held, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "accepted while output held")

endmodule
`default_nettype wire

// ----- sim/tb_fast_inverse_sqrt.sv -----
// Self-checking testbench for fast_inverse_sqrt: drives binary32 patterns over the
// input stream, predicts each result with a bit-exact binary32 model and compares.
// Depends on fis_pkg and the fast_inverse_sqrt RTL.
`default_nettype none
module tb_fast_inverse_sqrt;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxRounds   = 4;
  localparam int unsigned DrainCycles = 3 + fis_pkg::RoundLat * MaxRounds + 12;

  // Bit-exact binary32 arithmetic, round to nearest even, x86-style NaN rules.
  class inv_sqrt_scoreboard;
    logic [31:0] expected_q[$];
    logic [2:0]  rounds;
    int unsigned errors;

    function new();
      rounds = 3'd1;
      errors = 0;
    endfunction

    function bit is_nan(logic [31:0] a);
      return a[30:23] == fis_pkg::ExpMax && a[22:0] != 0;
    endfunction

    function bit is_inf(logic [31:0] a);
      return a[30:23] == fis_pkg::ExpMax && a[22:0] == 0;
    endfunction

    function void unpack(input logic [31:0] a, output logic [63:0] m, output int e);
      if (a[30:23] == 0) begin
        m = {41'd0, a[22:0]};
        e = -149;
      end else begin
        m = {40'd0, 1'b1, a[22:0]};
        e = int'(a[30:23]) - 150;
      end
    endfunction

    // Rounds sig * 2^e to binary32.
    function logic [31:0] pack(bit s, logic [63:0] sig, int e);
      int p, sh, lsb, be;
      logic [63:0] q;
      bit g, st;
      if (sig == 0) return {s, 31'd0};
      p = 63;
      while (!sig[p]) p--;
      if (e + p + 127 >= 1) sh = p - 23;
      else sh = -149 - e;
      if (sh > 0) begin
        if (sh > 64) begin
          q = 0; g = 0; st = 1;
        end else begin
          q  = sig >> sh;
          g  = sig[sh-1];
          st = (sig & ((64'd1 << (sh - 1)) - 1)) != 0;
        end
        if (g && (st || q[0])) q++;
      end else begin
        q = sig << (-sh);
      end
      lsb = e + sh;
      if (q[24]) begin
        q >>= 1;
        lsb++;
      end
      if (q[23]) begin
        be = lsb + 150;
        if (be >= 255) return {s, fis_pkg::ExpMax, 23'd0};
        return {s, be[7:0], q[22:0]};
      end
      return {s, 8'd0, q[22:0]};
    endfunction

    function logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
      logic [63:0] ma, mb;
      int ea, eb;
      bit s;
      s = a[31] ^ b[31];
      if (is_nan(a)) return a | fis_pkg::QuietBit;
      if (is_nan(b)) return b | fis_pkg::QuietBit;
      if (is_inf(a) || is_inf(b)) begin
        if (a[30:0] == 0 || b[30:0] == 0) return fis_pkg::DefaultNan;
        return {s, fis_pkg::ExpMax, 23'd0};
      end
      unpack(a, ma, ea);
      unpack(b, mb, eb);
      return pack(s, ma * mb, ea + eb);
    endfunction

    function logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
      logic [63:0] ma, mb, mbig, msml, res;
      int ea, eb, ebig, esml, sh;
      bit sbig, ssml, s;
      if (is_nan(a)) return a | fis_pkg::QuietBit;
      if (is_nan(b)) return b | fis_pkg::QuietBit;
      if (is_inf(a) && is_inf(b))
        return (a[31] != b[31]) ? fis_pkg::DefaultNan : a;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      unpack(a, ma, ea);
      unpack(b, mb, eb);
      if (ma == 0 && mb == 0) return {a[31] & b[31], 31'd0};
      if (ma == 0) return b;
      if (mb == 0) return a;
      if (ea >= eb) begin
        mbig = ma; ebig = ea; sbig = a[31]; msml = mb; esml = eb; ssml = b[31];
      end else begin
        mbig = mb; ebig = eb; sbig = b[31]; msml = ma; esml = ea; ssml = a[31];
      end
      // Align with 38 guard bits; anything shifted out below is jammed into bit 0.
      mbig = mbig << 38;
      sh = 38 - (ebig - esml);
      if (sh >= 0) msml = msml << sh;
      else if (-sh >= 64) msml = 64'd1;
      else msml = (msml >> (-sh)) | ((msml & ((64'd1 << (-sh)) - 1)) != 0);
      if (sbig == ssml) begin
        res = mbig + msml; s = sbig;
      end else if (mbig >= msml) begin
        res = mbig - msml; s = sbig;
      end else begin
        res = msml - mbig; s = ssml;
      end
      if (res == 0) return 32'd0;
      return pack(s, res, ebig - 38);
    endfunction

    function logic [31:0] fsub(logic [31:0] a, logic [31:0] b);
      if (!is_nan(a) && is_nan(b)) return b | fis_pkg::QuietBit;
      return fadd(a, b ^ 32'h8000_0000);
    endfunction

    function logic [31:0] inv_sqrt(logic [31:0] x);
      logic [31:0] xhalf, y, t;
      int n;
      xhalf = fmul(x, fis_pkg::HalfBits);
      y = fis_pkg::GuessMagic - (x >> 1);
      n = (rounds > MaxRounds) ? MaxRounds : rounds;
      for (int r = 0; r < n; r++) begin
        t = fmul(xhalf, y);
        t = fmul(t, y);
        t = fsub(fis_pkg::OneHalfBits, t);
        y = fmul(y, t);
      end
      return y;
    endfunction

    function void note_input(logic [31:0] x);
      expected_q.push_back(inv_sqrt(x));
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction: inv_sqrt_bits=%h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        $error("inv_sqrt_bits: expected %h, actual %h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i, cfg_ready_o;
  logic [2:0]  cfg_data_i;

  int unsigned send_idle, recv_idle, sent;
  inv_sqrt_scoreboard sb;

  fast_inverse_sqrt #(.MAX_ROUNDS(MaxRounds)) i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  task automatic push_x(logic [31:0] x);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(x);
    sent++;
    // Idle profile moves on as the item count grows.
    if (sent < 250) begin
      send_idle = 33; recv_idle = 58;
    end else if (sent < 500) begin
      send_idle = 58; recv_idle = 33;
    end else begin
      send_idle = 0; recv_idle = 0;
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_rounds(logic [2:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.rounds = v;
  endtask

  function automatic logic [31:0] random_x();
    int unsigned kind;
    logic [31:0] r;
    kind = $urandom_range(0, 99);
    r = $urandom;
    if (kind < 50) return {1'b0, 8'($urandom_range(90, 170)), r[22:0]};
    if (kind < 70) return r;
    if (kind < 85) return {r[31], 8'($urandom_range(0, 2)), r[22:0]};
    return {r[31], (r[0] ? fis_pkg::ExpMax : 8'($urandom_range(240, 254))), r[23:1]};
  endfunction

  logic [31:0] corner_x[$] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
    32'h7F80_0001, 32'hFFFF_FFFF, 32'h3F80_0000, 32'h4080_0000, 32'h0000_0001,
    32'h007F_FFFF, 32'h0080_0000, 32'h7F7F_FFFF, 32'hBF80_0000, 32'h0000_0002,
    32'h5F37_59DF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h3E80_0000
  };
  // Reset value first, then zero rounds, the maximum, saturating values and the rest.
  logic [2:0] round_plan[$] = '{3'd1, 3'd0, 3'd4, 3'd7, 3'd2, 3'd5, 3'd3, 3'd6, 3'd1};

  initial begin
    sb = new();
    send_idle = 33; recv_idle = 58; sent = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    cfg_valid_i = 1'b0; cfg_data_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (round_plan[p]) begin
      if (p > 0) write_rounds(round_plan[p]);
      foreach (corner_x[i]) push_x(corner_x[i]);
      repeat (64) push_x(random_x());
    end
    drain();
    if (sb.errors == 0) $display("fast_inverse_sqrt: match");
    else $display("fast_inverse_sqrt: mismatch");
    $finish;
  end

  initial begin
    #2ms;
    $display("fast_inverse_sqrt: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
